@@ hw/rtl/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_BACK  = 3'd1,
        KIND_INS_AT    = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_BACK  = 3'd4,
        KIND_DEL_AT    = 3'd5,
        KIND_READ_AT   = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // What the cell row does in the execute cycle.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef struct packed {
        logic go;
        t_op  op;
    } t_step;

    typedef logic signed [VALUE_W-1:0] t_value;

endpackage

`default_nettype wire

@@ hw/rtl/positional_list_engine.sv @@
// Top level of the positional list engine: command decode, cell row, result register.
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit words held in a row of cells, slot 0 at
// the front. A command is taken when start is high and busy is low. The next cycle
// (busy high) the cells shift, hold or load and the addressed word is picked out;
// the cycle after that o_valid is high for exactly one cycle with status, length
// and value. There is no back-pressure: capture the result in the o_valid cycle.
// A new command may be given in the o_valid cycle, but none is taken while busy; the
// pace is set by the command register followed by the cell update and word-select
// cycle.
module positional_list_engine #(
    parameter int DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output      logic                           busy,
    input  wire logic [ple_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [ple_pkg::POS_W-1:0]      i_position,
    input  wire logic signed [ple_pkg::VALUE_W-1:0] i_item_value,
    output      logic                           o_valid,
    output      logic [ple_pkg::STATUS_W-1:0]   o_status,
    output      logic [ple_pkg::LEN_W-1:0]      o_length,
    output      logic signed [ple_pkg::VALUE_W-1:0] o_out_value
);
    import ple_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_op             r_op, n_op;
    logic [IW-1:0]   r_pos;
    logic [PW-1:0]   n_pos;
    t_value          r_value;
    t_status         r_status, n_status;
    t_value          r_out_value;

    logic            accept;
    logic [PW-1:0]   count_ext;
    logic [PW-1:0]   pos_ext;
    logic            full;
    logic            empty;
    t_step           step;
    t_value          tap_or;

    t_value          w_value [DEPTH];
    t_value          w_tap   [DEPTH];

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    assign count_ext = PW'(r_count);
    assign pos_ext   = PW'(i_position);
    assign full      = (r_count == FULL_CNT);
    assign empty     = (r_count == '0);

    always_comb begin
        n_op     = OP_NONE;
        n_pos    = '0;
        n_status = ST_IGNORED;
        n_count  = r_count;
        case (i_kind) inside
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (i_kind == KIND_INS_FRONT) begin
                    n_op     = OP_INS;
                    n_status = ST_DONE;
                end else if (i_kind == KIND_INS_BACK) begin
                    n_op     = OP_INS;
                    n_pos    = count_ext;
                    n_status = ST_DONE;
                end else if (pos_ext <= count_ext) begin
                    n_op     = OP_INS;
                    n_pos    = pos_ext;
                    n_status = ST_DONE;
                end
                if (n_status == ST_DONE) begin
                    n_count = r_count + 1'b1;
                end
            end
            KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
                if (i_kind == KIND_DEL_FRONT && !empty) begin
                    n_op     = OP_DEL;
                    n_status = ST_DONE;
                end else if (i_kind == KIND_DEL_BACK && !empty) begin
                    n_op     = OP_DEL;
                    n_pos    = count_ext - 1'b1;
                    n_status = ST_DONE;
                end else if (i_kind == KIND_DEL_AT && pos_ext < count_ext) begin
                    n_op     = OP_DEL;
                    n_pos    = pos_ext;
                    n_status = ST_DONE;
                end
                if (n_status == ST_DONE) begin
                    n_count = r_count - 1'b1;
                end
            end
            KIND_READ_AT: begin
                if (pos_ext < count_ext) begin
                    n_op     = OP_READ;
                    n_pos    = pos_ext;
                    n_status = ST_DONE;
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = start ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = start ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_op    <= OP_NONE;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
                r_op    <= n_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos    <= n_pos[IW-1:0];
            r_value  <= i_item_value;
            r_status <= n_status;
        end
        if (busy) begin
            // capture the removed or read word before the row shifts
            r_out_value <= (r_op == OP_DEL || r_op == OP_READ) ? tap_or : '0;
        end
    end

    assign step.go = busy;
    assign step.op = r_op;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value left_w;
        t_value right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = w_value[g+1];
        end
        ple_cell #(
            .IW    (IW),
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_step       (step),
            .i_pos        (r_pos),
            .i_item_value (r_value),
            .i_left       (left_w),
            .i_right      (right_w),
            .o_value      (w_value[g]),
            .o_tap        (w_tap[g])
        );
    end

    // only the addressed cell drives a nonzero tap
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | w_tap[k];
        end
    end

    assign o_valid     = (r_state == S_RESP);
    assign o_status    = r_status;
    assign o_length    = LEN_W'(PW'(r_count));
    assign o_out_value = r_out_value;

endmodule

`default_nettype wire

@@ hw/rtl/ple_cell.sv @@
// One storage cell of the list: holds one slot and shifts with its neighbors.
`default_nettype none

module ple_cell #(
    parameter int IW    = 4,
    parameter int INDEX = 0
) (
    input  wire logic            i_clk,
    input  wire ple_pkg::t_step  i_step,
    input  wire logic [IW-1:0]   i_pos,
    input  wire ple_pkg::t_value i_item_value,
    input  wire ple_pkg::t_value i_left,
    input  wire ple_pkg::t_value i_right,
    output      ple_pkg::t_value o_value,
    output      ple_pkg::t_value o_tap
);
    import ple_pkg::*;

    localparam logic [IW-1:0] IDX = IW'(INDEX);

    t_value r_slot;
    t_value n_slot;
    logic   at_pos;
    logic   after_pos;

    assign at_pos    = (i_pos == IDX);
    assign after_pos = (IDX > i_pos);

    always_comb begin
        n_slot = r_slot;
        if (i_step.go) begin
            case (i_step.op)
                OP_INS: begin
                    // open the gap: later cells take the left word
                    if (after_pos) begin
                        n_slot = i_left;
                    end else if (at_pos) begin
                        n_slot = i_item_value;
                    end
                end
                OP_DEL: begin
                    // close the gap: this and later cells take the right word
                    if (after_pos || at_pos) begin
                        n_slot = i_right;
                    end
                end
                default: begin
                    n_slot = r_slot;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_value = r_slot;
    assign o_tap   = at_pos ? r_slot : '0;

endmodule

`default_nettype wire

@@ hw/rtl/ple_checker.sv @@
// Port-level checks for the positional list engine, bound to the top level.
`default_nettype none

module ple_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               o_valid,
    input wire logic [ple_pkg::STATUS_W-1:0]       o_status,
    input wire logic [ple_pkg::LEN_W-1:0]          o_length,
    input wire logic signed [ple_pkg::VALUE_W-1:0] o_out_value
);
    import ple_pkg::*;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH);

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_busy_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid && !busy)
        else $error("result strobe missing after execute cycle");

    a_zero_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> o_out_value == '0)
        else $error("nonzero value on ignored or refused word");

    a_full_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_length == FULL_LEN)
        else $error("full status with list not full");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (.*);

`default_nettype wire
